// ===== sv/ir_remote_key_press_classifier_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef IR_REMOTE_KEY_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define IR_REMOTE_KEY_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define IRKP_CHECK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("irkp check failed");

// Same, with a message of the caller's choice.
`define IRKP_CHECK_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ===== sv/irkp_pkg.sv =====
package irkp_pkg;

    typedef struct packed {
        logic        opcode;
        logic        frame_end;
        logic        frame_start_ok;
        logic        repeat_seen;
        logic [31:0] frame_word;
    } irkp_in_t;

    typedef struct packed {
        logic [1:0] press_kind;
        logic [7:0] key_value;
    } irkp_out_t;

    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] KIND_SHORT = 2'd0;
    localparam logic [1:0] KIND_LONG  = 2'd1;
    localparam logic [1:0] KIND_HOLD  = 2'd2;

    localparam logic [2:0] CFG_USER_CODE   = 3'd0;
    localparam logic [2:0] CFG_PERIOD      = 3'd1;
    localparam logic [2:0] CFG_SHORT_LIMIT = 3'd2;
    localparam logic [2:0] CFG_LONG_LIMIT  = 3'd3;
    localparam logic [2:0] CFG_HOLD_LIMIT  = 3'd4;

    localparam logic [15:0] RST_USER_CODE   = 16'd0;
    localparam logic [15:0] RST_PERIOD      = 16'd112;
    localparam logic [7:0]  RST_SHORT_LIMIT = 8'd3;
    localparam logic [7:0]  RST_LONG_LIMIT  = 8'd8;
    localparam logic [7:0]  RST_HOLD_LIMIT  = 8'd11;

    localparam logic [7:0]  COUNT_MAX = 8'hff;
    localparam logic [7:0]  KEY_CHECK = 8'hff;

endpackage

// ===== sv/ir_remote_key_press_classifier_unit.sv =====
// Channel | Direction | Handshake           | Payload
// cfg     | in        | cfg_we              | cfg_index, cfg_data
// in      | in        | in_valid / in_ready | in_data (irkp_in_t)
// out     | out       | out_valid/out_ready | out_data (irkp_out_t)
//
// One word per cycle: each accepted word updates the key state at its accepting
// edge, and a due result is loaded into the output register at that same edge.
// in_ready is low only while the output register holds an untaken result.
// Reset is asynchronous, active low; all but out_data_reg return to their defaults.
// A stall on the output side holds the result and stalls the input.
module ir_remote_key_press_classifier_unit
    import irkp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  irkp_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output irkp_out_t   out_data
);

    logic [15:0] user_code_reg;
    logic [15:0] period_reg;
    logic [7:0]  short_limit_reg;
    logic [7:0]  long_limit_reg;
    logic [7:0]  hold_limit_reg;

    logic        frame_valid_reg,   frame_valid_next;
    logic [7:0]  repeat_count_reg,  repeat_count_next;
    logic [7:0]  period_count_reg,  period_count_next;
    logic [7:0]  latched_key_reg,   latched_key_next;
    logic        hold_sent_reg,     hold_sent_next;
    logic        timer_running_reg, timer_running_next;
    logic [15:0] ticks_left_reg,    ticks_left_next;

    logic        out_valid_reg, out_valid_next;
    irkp_out_t   out_data_reg,  out_data_next;

    logic        accept;
    logic        emit;
    logic [1:0]  kind;
    logic [7:0]  pc_inc;
    logic [7:0]  key_byte;
    logic [7:0]  inv_byte;
    logic        frame_bad;
    logic        rc_zeroed;
    logic [7:0]  rc_base;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_code_reg   <= RST_USER_CODE;
            period_reg      <= RST_PERIOD;
            short_limit_reg <= RST_SHORT_LIMIT;
            long_limit_reg  <= RST_LONG_LIMIT;
            hold_limit_reg  <= RST_HOLD_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_USER_CODE:   user_code_reg   <= cfg_data;
                CFG_PERIOD:      period_reg      <= cfg_data;
                CFG_SHORT_LIMIT: short_limit_reg <= cfg_data[7:0];
                CFG_LONG_LIMIT:  long_limit_reg  <= cfg_data[7:0];
                CFG_HOLD_LIMIT:  hold_limit_reg  <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        frame_valid_next   = frame_valid_reg;
        repeat_count_next  = repeat_count_reg;
        period_count_next  = period_count_reg;
        latched_key_next   = latched_key_reg;
        hold_sent_next     = hold_sent_reg;
        timer_running_next = timer_running_reg;
        ticks_left_next    = ticks_left_reg;
        emit               = 1'b0;
        kind               = KIND_SHORT;

        key_byte  = in_data.frame_word[23:16];
        inv_byte  = in_data.frame_word[31:24];
        frame_bad = (in_data.frame_word[15:0] != user_code_reg)
                    || ((key_byte ^ inv_byte) != KEY_CHECK);
        rc_zeroed = in_data.frame_start_ok;
        rc_base   = rc_zeroed ? 8'd0 : repeat_count_reg;
        pc_inc    = (period_count_reg == COUNT_MAX) ? COUNT_MAX
                                                    : period_count_reg + 8'd1;

        if (accept)
        begin
            if (in_data.opcode == OP_EVENT)
            begin
                if (in_data.frame_start_ok)
                begin
                    frame_valid_next  = 1'b1;
                    repeat_count_next = 8'd0;
                end
                if (in_data.frame_end && (in_data.frame_start_ok || frame_valid_reg)
                    && frame_bad)
                begin
                    // drop the rest of this event, repeat code included
                    frame_valid_next = 1'b0;
                end
                else
                begin
                    if (in_data.frame_end && (in_data.frame_start_ok || frame_valid_reg))
                    begin
                        latched_key_next   = key_byte;
                        period_count_next  = 8'd0;
                        timer_running_next = 1'b1;
                        ticks_left_next    = period_reg;
                    end
                    if (in_data.repeat_seen && (rc_base != COUNT_MAX))
                        repeat_count_next = rc_base + 8'd1;
                end
            end
            else if (timer_running_reg)
            begin
                if (ticks_left_reg > 16'd1)
                begin
                    ticks_left_next = ticks_left_reg - 16'd1;
                end
                else if (pc_inc > repeat_count_reg)
                begin
                    // key released: classify and stop the timer
                    period_count_next = pc_inc;
                    if (repeat_count_reg < short_limit_reg)
                    begin
                        kind = KIND_SHORT;
                        emit = 1'b1;
                    end
                    else if (repeat_count_reg < long_limit_reg)
                    begin
                        kind = KIND_LONG;
                        emit = 1'b1;
                    end
                    else if (!hold_sent_reg)
                    begin
                        kind = KIND_HOLD;
                        emit = 1'b1;
                    end
                    hold_sent_next     = 1'b0;
                    timer_running_next = 1'b0;
                    ticks_left_next    = 16'd0;
                end
                else if (repeat_count_reg >= hold_limit_reg)
                begin
                    // still held: send a hold and reload both counts
                    kind              = KIND_HOLD;
                    emit              = 1'b1;
                    hold_sent_next    = 1'b1;
                    repeat_count_next = long_limit_reg;
                    period_count_next = long_limit_reg;
                    ticks_left_next   = period_reg;
                end
                else
                begin
                    period_count_next = pc_inc;
                    ticks_left_next   = period_reg;
                end
            end
        end

        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next           = 1'b1;
            out_data_next.press_kind = kind;
            out_data_next.key_value  = latched_key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg   <= 1'b0;
            repeat_count_reg  <= 8'd0;
            period_count_reg  <= 8'd0;
            latched_key_reg   <= 8'd0;
            hold_sent_reg     <= 1'b0;
            timer_running_reg <= 1'b0;
            ticks_left_reg    <= 16'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            frame_valid_reg   <= frame_valid_next;
            repeat_count_reg  <= repeat_count_next;
            period_count_reg  <= period_count_next;
            latched_key_reg   <= latched_key_next;
            hold_sent_reg     <= hold_sent_next;
            timer_running_reg <= timer_running_next;
            ticks_left_reg    <= ticks_left_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ===== sv/irkp_checker.sv =====
`include "ir_remote_key_press_classifier_unit_macros.svh"

module irkp_checker
    import irkp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [2:0]  cfg_index,
    input logic [15:0] cfg_data,
    input logic        in_valid,
    input logic        in_ready,
    input irkp_in_t    in_data,
    input logic        out_valid,
    input logic        out_ready,
    input irkp_out_t   out_data
);

    logic out_stall;
    logic tick_taken;

    assign out_stall  = out_valid && !out_ready;
    assign tick_taken = in_valid && in_ready && (in_data.opcode == OP_TICK);

    `IRKP_CHECK_MSG(a_out_hold, out_stall |=> out_valid && $stable(out_data), "held word changed")
    `IRKP_CHECK(a_ready_map, in_ready == (!out_valid || out_ready))
    `IRKP_CHECK(a_kind_legal, out_valid |-> out_data.press_kind != 2'd3)
    `IRKP_CHECK_MSG(a_from_tick, $rose(out_valid) |-> $past(tick_taken), "result without a tick")

endmodule

bind ir_remote_key_press_classifier_unit irkp_checker u_irkp_checker (.*);

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irkp_pkg::*;

    localparam int         CYCLE_LIMIT   = 300000;
    localparam int         HOLD_OFF_LEN  = 400;
    localparam int         PHASE_WORDS   = 10;
    localparam int         RANDOM_PHASES = 8;
    localparam logic [2:0] CFG_UNUSED    = 3'd7;

    // Tracks the key state and the press results still owed by the block.
    class key_press_tracker;
        logic [15:0] user_code;
        logic [15:0] period;
        logic [7:0]  short_lim;
        logic [7:0]  long_lim;
        logic [7:0]  hold_lim;

        bit          frame_valid;
        logic [7:0]  repeats;
        logic [7:0]  periods;
        logic [7:0]  key;
        bit          hold_sent;
        bit          timer_on;
        logic [15:0] ticks_left;

        irkp_out_t   due_presses[$];
        int          errors;

        function new();
            user_code   = RST_USER_CODE;
            period      = RST_PERIOD;
            short_lim   = RST_SHORT_LIMIT;
            long_lim    = RST_LONG_LIMIT;
            hold_lim    = RST_HOLD_LIMIT;
            frame_valid = 1'b0;
            repeats     = '0;
            periods     = '0;
            key         = '0;
            hold_sent   = 1'b0;
            timer_on    = 1'b0;
            ticks_left  = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_USER_CODE:   user_code = val;
                CFG_PERIOD:      period    = val;
                CFG_SHORT_LIMIT: short_lim = val[7:0];
                CFG_LONG_LIMIT:  long_lim  = val[7:0];
                CFG_HOLD_LIMIT:  hold_lim  = val[7:0];
                default: ;
            endcase
        endfunction

        function void period_expired();
            irkp_out_t p;
            bit        emit;
            bit        stop;
            emit = 1'b0;
            stop = 1'b0;
            p.key_value = key;
            p.press_kind = KIND_SHORT;
            if (periods != COUNT_MAX)
                periods++;
            if (periods > repeats)
            begin
                if (repeats < short_lim)
                begin
                    p.press_kind = KIND_SHORT;
                    emit = 1'b1;
                end
                else if (repeats < long_lim)
                begin
                    p.press_kind = KIND_LONG;
                    emit = 1'b1;
                end
                else if (!hold_sent)
                begin
                    p.press_kind = KIND_HOLD;
                    emit = 1'b1;
                end
                stop = 1'b1;
                hold_sent = 1'b0;
            end
            else if (repeats >= hold_lim)
            begin
                // key still down: report a hold and fall back to the long level
                hold_sent = 1'b1;
                p.press_kind = KIND_HOLD;
                emit = 1'b1;
                repeats = long_lim;
                periods = long_lim;
            end
            if (stop)
            begin
                timer_on = 1'b0;
                ticks_left = '0;
            end
            else
            begin
                ticks_left = period;
            end
            if (emit)
                due_presses.push_back(p);
        endfunction

        function void note_word(irkp_in_t w);
            if (w.opcode == OP_EVENT)
            begin
                if (w.frame_start_ok)
                begin
                    frame_valid = 1'b1;
                    repeats = '0;
                end
                if (w.frame_end && frame_valid)
                begin
                    if (w.frame_word[15:0] != user_code ||
                        (w.frame_word[23:16] ^ w.frame_word[31:24]) != KEY_CHECK)
                    begin
                        // bad frame: drop it, and the repeat flag with it
                        frame_valid = 1'b0;
                        return;
                    end
                    key = w.frame_word[23:16];
                    periods = '0;
                    timer_on = 1'b1;
                    ticks_left = period;
                end
                if (w.repeat_seen && repeats != COUNT_MAX)
                    repeats++;
                return;
            end
            if (!timer_on)
                return;
            if (ticks_left > 16'd1)
            begin
                ticks_left--;
                return;
            end
            period_expired();
        endfunction

        function void check_press(irkp_out_t r);
            irkp_out_t e;
            if (due_presses.size() == 0)
            begin
                $display("%0t: unexpected press: expected none, got kind %0d key %02h",
                         $time, r.press_kind, r.key_value);
                errors++;
                return;
            end
            e = due_presses.pop_front();
            if (r.press_kind !== e.press_kind)
            begin
                $display("%0t: press_kind mismatch: expected %0d, got %0d",
                         $time, e.press_kind, r.press_kind);
                errors++;
            end
            if (r.key_value !== e.key_value)
            begin
                $display("%0t: key_value mismatch: expected %02h, got %02h",
                         $time, e.key_value, r.key_value);
                errors++;
            end
        endfunction

        function int pending();
            return due_presses.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    irkp_in_t    in_data;
    logic        out_valid;
    logic        out_ready;
    irkp_out_t   out_data;

    key_press_tracker tracker;
    int idle_pct;
    int stall_pct;
    int pressure_starts;
    int sent_words;
    int cycle_count;

    ir_remote_key_press_classifier_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.check_press(out_data);
            if (in_valid && in_ready)
                tracker.note_word(in_data);
        end
    end

    // Output side: random stalls, plus a long hold-off on request.
    initial
    begin
        int seen;
        int hold_left;
        seen = 0;
        hold_left = 0;
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (seen != pressure_starts)
            begin
                seen = pressure_starts;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Enter and leave at a falling edge.
    task automatic drive_word(irkp_in_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_words++;
        @(negedge clk);
    endtask

    task automatic send_event(bit fs, bit fe, bit rep, logic [31:0] word);
        irkp_in_t w;
        w.opcode         = OP_EVENT;
        w.frame_start_ok = fs;
        w.frame_end      = fe;
        w.repeat_seen    = rep;
        w.frame_word     = word;
        drive_word(w);
    endtask

    // Event flags and word ride along with random content; the block ignores them.
    task automatic send_tick();
        irkp_in_t w;
        w.opcode         = OP_TICK;
        w.frame_start_ok = 1'($urandom_range(1));
        w.frame_end      = 1'($urandom_range(1));
        w.repeat_seen    = 1'($urandom_range(1));
        w.frame_word     = $urandom;
        drive_word(w);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        tracker.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic set_config(logic [15:0] uc, logic [15:0] per,
                              logic [7:0] s, logic [7:0] l, logic [7:0] h);
        logic [7:0] junk;
        junk = 8'($urandom);
        write_reg(CFG_USER_CODE, uc);
        write_reg(CFG_PERIOD, per);
        // upper byte of the limit registers is don't-care
        write_reg(CFG_SHORT_LIMIT, {junk, s});
        write_reg(CFG_LONG_LIMIT, {~junk, l});
        write_reg(CFG_HOLD_LIMIT, {junk ^ 8'h5a, h});
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [31:0] good_word(logic [7:0] k);
        return {~k, k, tracker.user_code};
    endfunction

    task automatic key_press();
        int          v;
        int          rate;
        int          steps;
        int          n;
        logic [7:0]  k;
        logic [31:0] w;
        v = $urandom_range(99);
        k = 8'($urandom);
        if (v < 80)
        begin
            if ($urandom_range(1))
                send_event(1'b1, 1'b1, 1'($urandom_range(1)), good_word(k));
            else
            begin
                send_event(1'b1, 1'b0, 1'($urandom_range(1)), $urandom);
                send_event(1'b0, 1'b1, 1'($urandom_range(1)), good_word(k));
            end
            // repeat rate picks short, long or held keys
            rate = $urandom_range(95);
            steps = $urandom_range(4, 40);
            n = 0;
            while (n < steps && tracker.timer_on)
            begin
                if ($urandom_range(99) < rate)
                    send_event(1'b0, 1'b0, 1'b1, $urandom);
                else
                    send_tick();
                n++;
            end
        end
        else if (v < 90)
        begin
            w = good_word(k);
            w[5'($urandom_range(31))] ^= 1'b1;
            send_event(1'($urandom_range(1)), 1'b1, 1'($urandom_range(1)), w);
        end
        else
            send_event(1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), $urandom);
    endtask

    initial
    begin
        int          p;
        int          phase_end;
        logic [7:0]  s;
        logic [7:0]  l;
        logic [7:0]  h;
        logic [15:0] uc;
        logic [15:0] per;

        tracker = new();
        idle_pct = 0;
        stall_pct = 0;
        pressure_starts = 0;
        sent_words = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_USER_CODE;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: idle tick, orphan and bad frames, short/long/hold, hold suppression
        set_config(16'ha5c3, 16'd1, 8'd1, 8'd3, 8'd4);
        write_reg(CFG_UNUSED, 16'hffff);
        cfg_we <= 1'b0;
        @(negedge clk);
        send_tick();
        send_event(1'b0, 1'b1, 1'b0, good_word(8'h3c));
        send_event(1'b1, 1'b1, 1'b1, 32'h0000_0000);
        send_event(1'b1, 1'b1, 1'b1, 32'hffff_ffff);
        send_event(1'b1, 1'b1, 1'b0, {8'hc3, 8'h3c, 16'ha5c2});
        send_event(1'b1, 1'b0, 1'b0, $urandom);
        send_event(1'b0, 1'b1, 1'b1, good_word(8'h00));
        send_tick();
        send_tick();
        send_event(1'b1, 1'b1, 1'b0, good_word(8'hff));
        send_tick();
        send_event(1'b1, 1'b1, 1'b1, good_word(8'h5a));
        repeat (4) send_event(1'b0, 1'b0, 1'b1, $urandom);
        repeat (3) send_tick();
        send_event(1'b0, 1'b0, 1'b0, 32'hffff_ffff);
        in_valid <= 1'b0;
        wait_drained();

        // saturate both counts; with long limit at max the hold repeats every period
        stall_pct = 37;
        set_config(16'($urandom), 16'd1, 8'd0, 8'hff, 8'hff);
        send_event(1'b1, 1'b1, 1'b0, good_word(8'($urandom)));
        repeat (258) send_event(1'b0, 1'b0, 1'b1, $urandom);
        repeat (12) send_tick();
        in_valid <= 1'b0;
        wait_drained();

        // longest period
        write_reg(CFG_PERIOD, 16'hffff);
        cfg_we <= 1'b0;
        @(negedge clk);
        send_tick();
        send_event(1'b1, 1'b1, 1'b1, good_word(8'($urandom)));
        repeat (6) send_tick();
        in_valid <= 1'b0;
        wait_drained();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 77;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 77;
                end
                default:
                begin
                    idle_pct = 37;
                    stall_pct = 37;
                end
            endcase
            uc  = (p == 0) ? 16'h0000 : (p == 1) ? 16'hffff : 16'($urandom);
            per = (p == 2 || p == 6) ? 16'd0 : 16'($urandom_range(1, 4));
            s   = 8'($urandom_range(0, 4));
            l   = 8'($urandom_range(0, 10));
            h   = 8'($urandom_range(0, 14));
            if (p == 3)
            begin
                s = 8'd0;
                l = 8'd0;
                h = 8'd0;
            end
            else if (p == 7)
            begin
                s = 8'hff;
                l = 8'hff;
                h = 8'hff;
            end
            set_config(uc, per, s, l, h);
            // long output stall while words keep coming: block must back up
            if (p == 5)
                pressure_starts++;
            phase_end = sent_words + PHASE_WORDS;
            while (sent_words < phase_end)
                key_press();
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/irkp_pkg.sv
sv/ir_remote_key_press_classifier_unit.sv
sv/irkp_checker.sv
verif/tb.sv
